[design/inverse_cdf_table_sampler_core_macros.svh]
// Assertion macros used by the sampler back end.
`ifndef INVERSE_CDF_TABLE_SAMPLER_CORE_MACROS_SVH
`define INVERSE_CDF_TABLE_SAMPLER_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define ICDF_ASSERT_IMP(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
// Next-cycle implication, checked out of reset.
`define ICDF_ASSERT_NXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define ICDF_ASSERT_IMP(label, clk, rst_n, a, b)
`define ICDF_ASSERT_NXT(label, clk, rst_n, a, b)
`endif
`endif

[design/icdf_pkg.sv]
// Shared constants and types of the inverse-CDF table sampler.
package icdf_pkg;
    localparam int TABLE_DEPTH = 128;
    localparam int IDX_W       = 7;
    localparam int PROB_W      = 17;
    localparam int LEN_W       = 32;
    localparam int PROD_W      = PROB_W + LEN_W;
    localparam int CMDQ_DEPTH  = 4;
    localparam int CMDQ_PTR_W  = $clog2(CMDQ_DEPTH);
    localparam int RESQ_DEPTH  = 2;
    localparam int RESQ_PTR_W  = $clog2(RESQ_DEPTH);

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    typedef struct packed {
        logic              op;
        logic [IDX_W-1:0]  entry_index;
        logic [PROB_W-1:0] entry_probability;
        logic [LEN_W-1:0]  entry_length;
        logic [PROB_W-1:0] draw_probability;
    } cmd_t;

    typedef struct packed {
        logic [LEN_W-1:0] sample_length;
        logic [IDX_W-1:0] segment_index;
    } res_t;
endpackage

[design/icdf_front.sv]
// Front end: accepts requests, classifies them and queues them for the back end.
module icdf_front import icdf_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic              op,
    input  logic [IDX_W-1:0]  entry_index,
    input  logic [PROB_W-1:0] entry_probability,
    input  logic [LEN_W-1:0]  entry_length,
    input  logic [PROB_W-1:0] draw_probability,
    output logic              cmd_valid,
    input  logic              cmd_ready,
    output cmd_t              cmd
);
    cmd_t                    q_mem [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [CMDQ_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CMDQ_PTR_W:0]     count_reg, count_next;
    logic                    do_wr, do_rd;
    cmd_t                    in_cmd;

    // Classify: only the fields the operation uses are kept
    always_comb
    begin
        in_cmd = '0;
        in_cmd.op = op;
        if (op == OP_LOAD)
        begin
            in_cmd.entry_index       = entry_index;
            in_cmd.entry_probability = entry_probability;
            in_cmd.entry_length      = entry_length;
        end
        else
        begin
            in_cmd.draw_probability = draw_probability;
        end
    end

    assign full      = (count_reg == (CMDQ_PTR_W+1)'(CMDQ_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd       = q_mem[rd_ptr_reg];
    assign do_wr     = push && !full;
    assign do_rd     = cmd_valid && cmd_ready;

    // Pointer and count update
    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (!do_wr && do_rd)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
            q_mem[wr_ptr_reg] <= in_cmd;
    end
endmodule

[design/icdf_back.sv]
// Back end: table writes, breakpoint search and interpolation with serial divide.
`include "inverse_cdf_table_sampler_core_macros.svh"
module icdf_back import icdf_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [IDX_W-1:0] entry_count,
    input  logic             cmd_valid,
    output logic             cmd_ready,
    input  cmd_t             cmd,
    output logic             res_push,
    input  logic             res_full,
    output res_t             res
);
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_ISSUE = 4'd1;
    localparam logic [3:0] ST_CHECK = 4'd2;
    localparam logic [3:0] ST_RD0   = 4'd3;
    localparam logic [3:0] ST_RD1   = 4'd4;
    localparam logic [3:0] ST_CAP   = 4'd5;
    localparam logic [3:0] ST_MUL   = 4'd6;
    localparam logic [3:0] ST_DIV   = 4'd7;
    localparam logic [3:0] ST_ADD   = 4'd8;
    localparam logic [3:0] ST_FIN   = 4'd9;
    localparam int         CNT_W    = $clog2(PROD_W);
    localparam int         SUM_W    = PROD_W + 2;

    logic [PROB_W-1:0] pmem [TABLE_DEPTH];
    logic [LEN_W-1:0]  lmem [TABLE_DEPTH];
    logic [PROB_W-1:0] p_rd_reg;
    logic [LEN_W-1:0]  l_rd_reg;

    logic [3:0]        state_reg, state_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [PROB_W-1:0] draw_reg;
    logic [PROB_W-1:0] p0_reg;
    logic [LEN_W-1:0]  l0_reg;
    logic [PROB_W-1:0] amag_reg, dmag_reg;
    logic [LEN_W-1:0]  bmag_reg;
    logic              neg_reg;
    logic [PROD_W-1:0] n_reg;
    logic [PROB_W-1:0] rem_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [LEN_W-1:0]  len_reg;

    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;
    logic [IDX_W-1:0]  idx_min1;
    logic [PROB_W:0]   rem_shift, rem_sub;
    logic              qbit;
    logic [SUM_W-1:0]  sum;
    logic [SUM_W-1:0]  q_ext;

    assign cmd_ready = (state_reg == ST_IDLE);
    assign wr_en     = cmd_ready && cmd_valid && (cmd.op == OP_LOAD);
    assign res_push  = (state_reg == ST_FIN) && !res_full;
    assign res.sample_length = len_reg;
    assign res.segment_index = idx_reg;
    assign idx_min1  = (idx_reg == '0) ? IDX_W'(1) : idx_reg;

    // Table memories: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            pmem[cmd.entry_index] <= cmd.entry_probability;
            lmem[cmd.entry_index] <= cmd.entry_length;
        end
        p_rd_reg <= pmem[rd_addr];
        l_rd_reg <= lmem[rd_addr];
    end

    // Read address per state
    always_comb
    begin
        case (state_reg)
            ST_RD0:  rd_addr = idx_reg - 1'b1;
            default: rd_addr = idx_reg;
        endcase
    end

    // Divider step: restoring, one quotient bit a cycle
    assign rem_shift = {rem_reg, n_reg[PROD_W-1]};
    assign qbit      = (rem_shift >= {1'b0, dmag_reg});
    assign rem_sub   = qbit ? rem_shift - {1'b0, dmag_reg} : rem_shift;

    // Final add of the signed quotient to the lower length
    assign q_ext = {2'b00, n_reg};
    assign sum   = {{(SUM_W-LEN_W){1'b0}}, l0_reg} + (neg_reg ? (~q_ext + 1'b1) : q_ext);

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid && cmd.op == OP_SAMPLE)
                begin
                    idx_next   = '0;
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                if (idx_reg >= entry_count)
                begin
                    idx_next   = idx_min1;
                    state_next = ST_RD0;
                end
                else
                    state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (p_rd_reg < draw_reg)
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_ISSUE;
                end
                else
                begin
                    idx_next   = idx_min1;
                    state_next = ST_RD0;
                end
            end
            ST_RD0:  state_next = ST_RD1;
            ST_RD1:  state_next = ST_CAP;
            ST_CAP:  state_next = (p_rd_reg == p0_reg) ? ST_FIN : ST_MUL;
            ST_MUL:  state_next = ST_DIV;
            ST_DIV:  state_next = (cnt_reg == CNT_W'(PROD_W-1)) ? ST_ADD : ST_DIV;
            ST_ADD:  state_next = ST_FIN;
            ST_FIN:  state_next = res_full ? ST_FIN : ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
                draw_reg <= cmd.draw_probability;
            ST_RD1:
            begin
                p0_reg <= p_rd_reg;
                l0_reg <= l_rd_reg;
            end
            ST_CAP:
            begin
                // Magnitudes of the three differences and the combined sign
                amag_reg <= (draw_reg < p0_reg) ? p0_reg - draw_reg : draw_reg - p0_reg;
                bmag_reg <= (l_rd_reg < l0_reg) ? l0_reg - l_rd_reg : l_rd_reg - l0_reg;
                dmag_reg <= (p_rd_reg < p0_reg) ? p0_reg - p_rd_reg : p_rd_reg - p0_reg;
                neg_reg  <= (draw_reg < p0_reg) ^ (l_rd_reg < l0_reg) ^ (p_rd_reg < p0_reg);
                len_reg  <= l_rd_reg;
            end
            ST_MUL:
            begin
                n_reg   <= PROD_W'(amag_reg) * PROD_W'(bmag_reg);
                rem_reg <= '0;
                cnt_reg <= '0;
            end
            ST_DIV:
            begin
                // remainder stays below the divisor, so it fits in PROB_W bits
                rem_reg <= rem_sub[PROB_W-1:0];
                n_reg   <= {n_reg[PROD_W-2:0], qbit};
                cnt_reg <= cnt_reg + 1'b1;
            end
            ST_ADD:
            begin
                // Saturate to the unsigned 32-bit range
                if (sum[SUM_W-1])
                    len_reg <= '0;
                else if (sum[SUM_W-2:LEN_W] != '0)
                    len_reg <= '1;
                else
                    len_reg <= sum[LEN_W-1:0];
            end
            default: ;
        endcase
    end

    // Checks
    `ICDF_ASSERT_IMP(a_div_nonzero, clk, rst_n, state_reg == ST_DIV, dmag_reg != '0)
    `ICDF_ASSERT_IMP(a_seg_nonzero, clk, rst_n, res_push, idx_reg != '0)
    `ICDF_ASSERT_IMP(a_search_bound, clk, rst_n, state_reg == ST_CHECK, idx_reg < entry_count)
    `ICDF_ASSERT_NXT(a_push_to_idle, clk, rst_n, res_push, state_reg == ST_IDLE)
endmodule

[design/icdf_outq.sv]
// Result queue between the back end and the result ports.
module icdf_outq import icdf_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic wr,
    output logic full,
    input  res_t wdata,
    output logic empty,
    input  logic pop,
    output res_t rdata
);
    res_t                  q_mem [RESQ_DEPTH];
    logic [RESQ_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [RESQ_PTR_W:0]   count_reg, count_next;
    logic                  do_wr, do_rd;

    assign full  = (count_reg == (RESQ_PTR_W+1)'(RESQ_DEPTH));
    assign empty = (count_reg == '0);
    assign rdata = q_mem[rd_ptr_reg];
    assign do_wr = wr && !full;
    assign do_rd = pop && !empty;

    // Occupancy
    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (!do_wr && do_rd)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_rd)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            q_mem[wr_ptr_reg] <= wdata;
    end
endmodule

[design/inverse_cdf_table_sampler_core.sv]
// Top level of the inverse-CDF table sampler.
// A load request writes one table entry; the back end takes it without leaving idle.
// A sample request searches the breakpoints for the first one at or above the draw,
// stopping at entry_count if none comes first. The search reads the table through
// the single registered read port, alternating an issue and a check state per entry;
// the interpolation runs a 17x32 multiply and a restoring divide, one quotient bit a
// cycle, and equal breakpoints skip both.
// Up to four requests queue ahead of the back end and two results behind it.
// entry_count is written through cfg_wen/cfg_wdata; the user must do so only while
// the block is idle, as the block itself does not enforce it.
module inverse_cdf_table_sampler_core import icdf_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic              op,
    input  logic [IDX_W-1:0]  entry_index,
    input  logic [PROB_W-1:0] entry_probability,
    input  logic [LEN_W-1:0]  entry_length,
    input  logic [PROB_W-1:0] draw_probability,
    output logic              empty,
    input  logic              pop,
    output logic [LEN_W-1:0]  sample_length,
    output logic [IDX_W-1:0]  segment_index,
    input  logic              cfg_wen,
    input  logic [IDX_W-1:0]  cfg_wdata
);
    logic [IDX_W-1:0] entry_count_reg;
    logic             cmd_valid, cmd_ready;
    cmd_t             cmd;
    logic             res_push, res_full;
    res_t             res_in, res_out;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            entry_count_reg <= IDX_W'(1);
        else if (cfg_wen)
            entry_count_reg <= cfg_wdata;
    end

    icdf_front u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .push              (push),
        .full              (full),
        .op                (op),
        .entry_index       (entry_index),
        .entry_probability (entry_probability),
        .entry_length      (entry_length),
        .draw_probability  (draw_probability),
        .cmd_valid         (cmd_valid),
        .cmd_ready         (cmd_ready),
        .cmd               (cmd)
    );

    icdf_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .entry_count (entry_count_reg),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .cmd         (cmd),
        .res_push    (res_push),
        .res_full    (res_full),
        .res         (res_in)
    );

    icdf_outq u_outq (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (res_push),
        .full  (res_full),
        .wdata (res_in),
        .empty (empty),
        .pop   (pop),
        .rdata (res_out)
    );

    assign sample_length = res_out.sample_length;
    assign segment_index = res_out.segment_index;
endmodule

[tb/tb_top.sv]
// Self-checking testbench for the inverse-CDF table sampler core.
module tb_top;
    import icdf_pkg::*;

    localparam int CYCLE_LIMIT = 1_200_000;
    localparam int DRAIN_WAIT  = 400;
    localparam int LOAD_SETTLE = 30;

    logic              clk;
    logic              rst_n;
    logic              push;
    logic              full;
    logic              op;
    logic [IDX_W-1:0]  entry_index;
    logic [PROB_W-1:0] entry_probability;
    logic [LEN_W-1:0]  entry_length;
    logic [PROB_W-1:0] draw_probability;
    logic              empty;
    logic              pop;
    logic [LEN_W-1:0]  sample_length;
    logic [IDX_W-1:0]  segment_index;
    logic              cfg_wen;
    logic [IDX_W-1:0]  cfg_wdata;

    inverse_cdf_table_sampler_core uut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .op(op),
        .entry_index(entry_index), .entry_probability(entry_probability),
        .entry_length(entry_length), .draw_probability(draw_probability),
        .empty(empty), .pop(pop), .sample_length(sample_length),
        .segment_index(segment_index), .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata)
    );

    // directed stimulus row; expected result typed only where obvious
    typedef struct {
        logic              op;
        logic [IDX_W-1:0]  idx;
        logic [PROB_W-1:0] prob;
        logic [LEN_W-1:0]  len;
        logic [PROB_W-1:0] draw;
        bit                typed;
        logic [LEN_W-1:0]  exp_len;
        logic [IDX_W-1:0]  exp_seg;
    } dir_row_t;

    // predictor copy of the table and the search bound
    logic [PROB_W-1:0] prob_tbl [TABLE_DEPTH];
    logic [LEN_W-1:0]  len_tbl [TABLE_DEPTH];
    logic [IDX_W-1:0]  entry_count_q;

    res_t   samples_due[$];
    int     fails;
    int     cycle_cnt;
    int     snd_idle_pct;
    int     rcv_idle_pct;
    int     hold_left;
    bit     hold_go;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // interpolated sample for one draw against the current table
    function automatic res_t sample_of(logic [PROB_W-1:0] draw);
        int     limit;
        int     i;
        longint p0, p1, l0, l1, h;
        res_t   r;
        limit = entry_count_q;
        if (limit > TABLE_DEPTH - 1)
            limit = TABLE_DEPTH - 1;
        i = 0;
        while (i < limit && prob_tbl[i] < draw)
            i++;
        if (i < 1)
            i = 1;
        p0 = prob_tbl[i-1];
        p1 = prob_tbl[i];
        l0 = len_tbl[i-1];
        l1 = len_tbl[i];
        if (p1 == p0)
            h = l1;
        else
            h = l0 + ((longint'(draw) - p0) * (l1 - l0)) / (p1 - p0);
        if (h < 0)
            h = 0;
        if (h > 64'hFFFF_FFFF)
            h = 64'hFFFF_FFFF;
        r.sample_length = h[31:0];
        r.segment_index = i[IDX_W-1:0];
        return r;
    endfunction

    // offer one request; returns once it is accepted
    task automatic send_request(logic o, logic [IDX_W-1:0] idx, logic [PROB_W-1:0] prob,
                                logic [LEN_W-1:0] len, logic [PROB_W-1:0] draw,
                                bit typed, res_t typed_res);
        res_t r;
        while ($urandom_range(99) < snd_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push              <= 1'b1;
        op                <= o;
        entry_index       <= idx;
        entry_probability <= prob;
        entry_length      <= len;
        draw_probability  <= draw;
        do
            @(posedge clk);
        while (full);
        if (o == OP_LOAD)
        begin
            prob_tbl[idx] = prob;
            len_tbl[idx]  = len;
        end
        else
        begin
            r = sample_of(draw);
            samples_due.push_back(typed ? typed_res : r);
        end
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        @(posedge clk);
        while (samples_due.size() != 0)
            @(posedge clk);
    endtask

    // entry_count write, only with the block idle
    task automatic write_entry_count(logic [IDX_W-1:0] v);
        wait_drained();
        repeat (LOAD_SETTLE) @(posedge clk);
        cfg_wen   <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_wen <= 1'b0;
        entry_count_q = v;
    endtask

    // load the whole table: monotonic CDF or random noise
    task automatic fill_table(bit monotonic);
        longint p, l;
        res_t   nil;
        nil = '0;
        p = $urandom_range(0, 1000);
        l = $urandom_range(0, 1 << 20);
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            if (monotonic)
                send_request(OP_LOAD, IDX_W'(i), p[PROB_W-1:0], l[LEN_W-1:0], '0, 0, nil);
            else
                send_request(OP_LOAD, IDX_W'(i), PROB_W'($urandom_range(0, 131071)),
                             $urandom, '0, 0, nil);
            p = p + $urandom_range(0, 1030);
            if (p > 65536)
                p = 65536;
            l = l + $urandom_range(0, 1 << 26);
            if (l > 64'hFFFF_FFFF)
                l = 64'hFFFF_FFFF;
        end
    endtask

    // result side: random pop, long hold on request, check against oldest
    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && pop && !empty)
        begin
            if (samples_due.size() == 0)
            begin
                $error("result with no sample request outstanding");
                fails++;
            end
            else
            begin
                want = samples_due.pop_front();
                if (sample_length !== want.sample_length)
                begin
                    $error("sample_length expected %h actual %h",
                           want.sample_length, sample_length);
                    fails++;
                end
                if (segment_index !== want.segment_index)
                begin
                    $error("segment_index expected %0d actual %0d",
                           want.segment_index, segment_index);
                    fails++;
                end
            end
        end
        if (hold_go)
        begin
            hold_go   = 0;
            hold_left = 600;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            pop <= 1'b0;
        end
        else
            pop <= ($urandom_range(99) >= rcv_idle_pct);
    end

    initial
    begin
        dir_row_t dir_rows[$];
        res_t     tr;
        logic [IDX_W-1:0] cfg_vals[6];
        int       n;

        push = 0; op = 0; entry_index = 0; entry_probability = 0; entry_length = 0;
        draw_probability = 0; pop = 0; cfg_wen = 0; cfg_wdata = 0;
        fails = 0; cycle_cnt = 0; hold_left = 0; hold_go = 0;
        entry_count_q = 1;
        foreach (prob_tbl[i])
        begin
            prob_tbl[i] = '0;
            len_tbl[i]  = '0;
        end
        snd_idle_pct = 35;
        rcv_idle_pct = 88;
        rst_n = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1;

        // directed part with reset bound of 1
        dir_rows = '{
            '{OP_LOAD,   0, 32768, 0,            0,      0, 0, 0},
            '{OP_LOAD,   1, 65536, 32'h10000,    0,      0, 0, 0},
            '{OP_SAMPLE, 0, 0,     0,            32768,  1, 32'h0, 1},
            '{OP_SAMPLE, 0, 0,     0,            65536,  1, 32'h10000, 1},
            // below the segment: saturates to zero
            '{OP_SAMPLE, 0, 0,     0,            0,      1, 32'h0, 1},
            // above the segment: extrapolated
            '{OP_SAMPLE, 0, 0,     0,            131071, 1, 32'd196606, 1},
            '{OP_SAMPLE, 0, 0,     0,            49152,  0, 0, 0},
            '{OP_LOAD,   1, 65536, 32'hFFFFFFFF, 0,      0, 0, 0},
            // saturates to the top
            '{OP_SAMPLE, 0, 0,     0,            131071, 1, 32'hFFFFFFFF, 1},
            // equal breakpoints give the upper length
            '{OP_LOAD,   0, 65536, 5,            0,      0, 0, 0},
            '{OP_LOAD,   1, 65536, 32'h1234,     0,      0, 0, 0},
            '{OP_SAMPLE, 0, 0,     0,            65536,  1, 32'h1234, 1},
            '{OP_LOAD,   0, 0,     0,            0,      0, 0, 0},
            '{OP_LOAD,   1, 131071, 32'hFFFFFFFF, 0,     0, 0, 0},
            '{OP_SAMPLE, 0, 0,     0,            131071, 1, 32'hFFFFFFFF, 1},
            '{OP_SAMPLE, 0, 0,     0,            1,      0, 0, 0},
            // falling segment, truncation toward zero
            '{OP_LOAD,   0, 32768, 1000,         0,      0, 0, 0},
            '{OP_LOAD,   1, 65536, 0,            0,      0, 0, 0},
            '{OP_SAMPLE, 0, 0,     0,            49152,  1, 32'd500, 1},
            '{OP_SAMPLE, 0, 0,     0,            32769,  0, 0, 0},
            '{OP_LOAD,   127, 131071, 32'hFFFFFFFF, 0,   0, 0, 0}
        };
        foreach (dir_rows[k])
        begin
            tr.sample_length = dir_rows[k].exp_len;
            tr.segment_index = dir_rows[k].exp_seg;
            send_request(dir_rows[k].op, dir_rows[k].idx, dir_rows[k].prob,
                         dir_rows[k].len, dir_rows[k].draw, dir_rows[k].typed, tr);
        end

        // random part: three idle modes, two bounds each
        cfg_vals = '{127, IDX_W'($urandom_range(2, 126)), 0, 1,
                     IDX_W'($urandom_range(2, 126)), 127};
        for (int m = 0; m < 3; m++)
        begin
            wait_drained();
            snd_idle_pct = (m == 0) ? 35 : (m == 1) ? 88 : 0;
            rcv_idle_pct = (m == 0) ? 88 : (m == 1) ? 35 : 0;
            fill_table(m != 2);
            for (int s = 0; s < 2; s++)
            begin
                write_entry_count(cfg_vals[2*m + s]);
                if (m == 2 && s == 0)
                    hold_go = 1;
                n = 0;
                while (n < 110)
                begin
                    tr = '0;
                    if (m == 0 && s == 1 && n == 50)
                        wait_drained();
                    if ($urandom_range(9) == 0)
                        send_request(OP_LOAD, IDX_W'($urandom_range(0, 127)),
                                     PROB_W'($urandom_range(0, 131071)), $urandom,
                                     PROB_W'($urandom), 0, tr);
                    else if ($urandom_range(3) == 0)
                        send_request(OP_SAMPLE, IDX_W'($urandom), PROB_W'($urandom),
                                     $urandom, PROB_W'($urandom_range(0, 131071)), 0, tr);
                    else
                        send_request(OP_SAMPLE, IDX_W'($urandom), PROB_W'($urandom),
                                     $urandom, PROB_W'($urandom_range(32768, 65536)), 0, tr);
                    n++;
                end
            end
        end

        // drain and finish
        wait_drained();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (fails == 0 && samples_due.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
